### hw/rtl/fdr_pkg.sv
// types, constants and step functions of the dielectric fresnel reflectance pipeline
package fdr_pkg;

    localparam int COS_FRAC_BITS = 15;
    localparam int OUT_FRAC_BITS = 16;
    localparam int RATIO_BITS    = 31;

    localparam int FIELD_W  = 16;
    localparam int COS_W    = COS_FRAC_BITS + 2;
    localparam int ROOT_W   = COS_FRAC_BITS + 1;
    localparam int ARG_W    = 2 * COS_FRAC_BITS + 1;
    localparam int PROD_W   = 2 * FIELD_W;
    localparam int QUO_W    = COS_FRAC_BITS;
    localparam int AMP_W    = FIELD_W + COS_W;
    localparam int SUM_W    = AMP_W + 1;
    localparam int RSQ_W    = 2 * RATIO_BITS + 1;
    localparam int REFL_W   = 17;
    localparam int REFL_SHIFT = 2 * RATIO_BITS + 1 - OUT_FRAC_BITS;

    localparam logic [COS_W-1:0]  COS_ONE  = COS_W'(1) << COS_FRAC_BITS;
    localparam logic [REFL_W-1:0] REFL_ONE = REFL_W'(64'(1) << OUT_FRAC_BITS);

    typedef struct packed {
        logic signed [FIELD_W-1:0] cos_incident;
        logic [FIELD_W-1:0]        index_incident;
        logic [FIELD_W-1:0]        index_transmit;
    } req_t;

    typedef struct packed {
        logic [REFL_W-1:0] reflectance;
        logic              total_reflection;
    } rsp_t;

    typedef struct packed {
        logic [COS_W-1:0]   c;
        logic [FIELD_W-1:0] ni;
        logic [FIELD_W-1:0] nt;
        logic               tir;
    } carry_t;

    typedef struct packed {
        logic [ARG_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic [SUM_W-1:0]      s;
        logic [SUM_W-1:0]      rem;
        logic [RATIO_BITS-1:0] quo;
        logic                  one;
    } lane_t;

    // one result bit of the integer square root, bit k
    function automatic sqrt_t sqrt_step(sqrt_t a, int k);
        logic [ARG_W:0] inc;
        sqrt_t          b;
        b   = a;
        inc = ((ARG_W + 1)'(a.root) << (k + 1)) + ((ARG_W + 1)'(1) << (2 * k));
        if ({1'b0, a.rem} >= inc)
        begin
            b.rem  = ARG_W'({1'b0, a.rem} - inc);
            b.root = a.root | (ROOT_W'(1) << k);
        end
        return b;
    endfunction

    // one bit of the amplitude ratio quotient
    function automatic lane_t lane_step(lane_t a);
        logic [SUM_W:0] r2;
        lane_t          b;
        b  = a;
        r2 = {a.rem, 1'b0};
        if (r2 >= {1'b0, a.s})
        begin
            r2    = r2 - {1'b0, a.s};
            b.quo = {a.quo[RATIO_BITS-2:0], 1'b1};
        end
        else
        begin
            b.quo = {a.quo[RATIO_BITS-2:0], 1'b0};
        end
        b.rem = r2[SUM_W-1:0];
        return b;
    endfunction

endpackage

### hw/rtl/fresnel_dielectric_reflectance.sv
// Unpolarised Fresnel reflectance of a dielectric boundary, fully pipelined.
// One request is taken every cycle while the pipe advances, and each gives one
// response; the pipe has 7 + 2*16 + 15 + 31 register stages: two 16-step bit-serial
// square roots, a 15-step divider for the transmitted sine and a 31-step
// divider pair for the amplitude ratios, each step a register stage of its own.
// The whole pipe advances together and holds while the response is not taken.
module fresnel_dielectric_reflectance
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  fdr_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output fdr_pkg::rsp_t rsp
);

    localparam int NSQ = fdr_pkg::ROOT_W;
    localparam int NDV = fdr_pkg::QUO_W;
    localparam int NRT = fdr_pkg::RATIO_BITS;
    localparam int NST = 7 + 2 * NSQ + NDV + NRT;
    localparam int CF  = fdr_pkg::COS_FRAC_BITS;

    logic [NST-1:0] valid_reg;
    logic           adv;

    assign adv       = ~valid_reg[NST-1] | rsp_ready;
    assign req_ready = adv;
    assign rsp_valid = valid_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[NST-2:0], req_valid};
    end

    // front: direction, swap, 1 - c^2
    logic                       entering;
    logic [fdr_pkg::COS_W-1:0]  c_raw;
    logic [fdr_pkg::COS_W-1:0]  c_clamp;
    logic [2*fdr_pkg::COS_W-1:0] c_sq;
    fdr_pkg::carry_t            f_carry_reg;
    logic [fdr_pkg::ARG_W-1:0]  f_arg_reg;

    assign entering = (req.cos_incident != '0) && !req.cos_incident[fdr_pkg::FIELD_W-1];
    always_comb
    begin
        if (entering)
            c_raw = {1'b0, req.cos_incident};
        else if (req.cos_incident[fdr_pkg::FIELD_W-1])
            c_raw = (fdr_pkg::COS_W'(1) << fdr_pkg::FIELD_W) - {1'b0, req.cos_incident};
        else
            c_raw = '0;
        c_clamp = (c_raw > fdr_pkg::COS_ONE) ? fdr_pkg::COS_ONE : c_raw;
    end
    assign c_sq = c_clamp * c_clamp;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_carry_reg.c   <= c_clamp;
            f_carry_reg.ni  <= entering ? req.index_incident : req.index_transmit;
            f_carry_reg.nt  <= entering ? req.index_transmit : req.index_incident;
            f_carry_reg.tir <= 1'b0;
            f_arg_reg <= fdr_pkg::ARG_W'(((2*fdr_pkg::COS_W)'(1) << (2 * CF)) - c_sq);
        end
    end

    // square root of 1 - c^2
    fdr_pkg::sqrt_t  sq1_reg [NSQ];
    fdr_pkg::carry_t sq1_carry_reg [NSQ];

    for (genvar i = 0; i < NSQ; i++)
    begin : g_sq1
        fdr_pkg::sqrt_t  sq_in;
        fdr_pkg::carry_t carry_in;

        if (i == 0)
        begin : g_first
            assign sq_in    = {f_arg_reg, fdr_pkg::ROOT_W'(0)};
            assign carry_in = f_carry_reg;
        end
        else
        begin : g_next
            assign sq_in    = sq1_reg[i-1];
            assign carry_in = sq1_carry_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq1_reg[i]       <= fdr_pkg::sqrt_step(sq_in, NSQ - 1 - i);
                sq1_carry_reg[i] <= carry_in;
            end
        end
    end

    // ni * sin_i and total reflection test
    logic [fdr_pkg::PROD_W-1:0] prod;
    fdr_pkg::carry_t            t_carry_reg;
    logic [fdr_pkg::PROD_W-1:0] t_prod_reg;

    assign prod = sq1_carry_reg[NSQ-1].ni * sq1_reg[NSQ-1].root;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_carry_reg.c   <= sq1_carry_reg[NSQ-1].c;
            t_carry_reg.ni  <= sq1_carry_reg[NSQ-1].ni;
            t_carry_reg.nt  <= sq1_carry_reg[NSQ-1].nt;
            t_carry_reg.tir <= (sq1_carry_reg[NSQ-1].nt == '0) ||
                (prod >= (fdr_pkg::PROD_W'(sq1_carry_reg[NSQ-1].nt) << CF));
            t_prod_reg      <= prod;
        end
    end

    // sin_t = ni * sin_i / nt
    logic [fdr_pkg::PROD_W-1:0] dv_rem_reg [NDV];
    logic [fdr_pkg::QUO_W-1:0]  dv_quo_reg [NDV];
    fdr_pkg::carry_t            dv_carry_reg [NDV];

    for (genvar i = 0; i < NDV; i++)
    begin : g_dv
        logic [fdr_pkg::PROD_W-1:0] rem_in;
        logic [fdr_pkg::QUO_W-1:0]  quo_in;
        fdr_pkg::carry_t            carry_in;
        logic [fdr_pkg::PROD_W-1:0] den;

        if (i == 0)
        begin : g_first
            assign rem_in   = t_prod_reg;
            assign quo_in   = '0;
            assign carry_in = t_carry_reg;
        end
        else
        begin : g_next
            assign rem_in   = dv_rem_reg[i-1];
            assign quo_in   = dv_quo_reg[i-1];
            assign carry_in = dv_carry_reg[i-1];
        end
        assign den = fdr_pkg::PROD_W'(carry_in.nt) << (NDV - 1 - i);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_carry_reg[i] <= carry_in;
                if (rem_in >= den)
                begin
                    dv_rem_reg[i] <= rem_in - den;
                    dv_quo_reg[i] <= quo_in | (fdr_pkg::QUO_W'(1) << (NDV - 1 - i));
                end
                else
                begin
                    dv_rem_reg[i] <= rem_in;
                    dv_quo_reg[i] <= quo_in;
                end
            end
        end
    end

    // 1 - sin_t^2
    logic [2*fdr_pkg::QUO_W-1:0] st_sq;
    fdr_pkg::carry_t             a2_carry_reg;
    logic [fdr_pkg::ARG_W-1:0]   a2_arg_reg;

    assign st_sq = dv_quo_reg[NDV-1] * dv_quo_reg[NDV-1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a2_carry_reg <= dv_carry_reg[NDV-1];
            a2_arg_reg   <= (fdr_pkg::ARG_W'(1) << (2 * CF)) - fdr_pkg::ARG_W'(st_sq);
        end
    end

    // cos_t
    fdr_pkg::sqrt_t  sq2_reg [NSQ];
    fdr_pkg::carry_t sq2_carry_reg [NSQ];

    for (genvar i = 0; i < NSQ; i++)
    begin : g_sq2
        fdr_pkg::sqrt_t  sq_in;
        fdr_pkg::carry_t carry_in;

        if (i == 0)
        begin : g_first
            assign sq_in    = {a2_arg_reg, fdr_pkg::ROOT_W'(0)};
            assign carry_in = a2_carry_reg;
        end
        else
        begin : g_next
            assign sq_in    = sq2_reg[i-1];
            assign carry_in = sq2_carry_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq2_reg[i]       <= fdr_pkg::sqrt_step(sq_in, NSQ - 1 - i);
                sq2_carry_reg[i] <= carry_in;
            end
        end
    end

    // amplitude terms
    logic [fdr_pkg::AMP_W-1:0] p1_reg, q1_reg, p2_reg, q2_reg;
    logic                      m_tir_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg    <= sq2_carry_reg[NSQ-1].nt * sq2_carry_reg[NSQ-1].c;
            q1_reg    <= sq2_carry_reg[NSQ-1].ni * {1'b0, sq2_reg[NSQ-1].root};
            p2_reg    <= sq2_carry_reg[NSQ-1].ni * sq2_carry_reg[NSQ-1].c;
            q2_reg    <= sq2_carry_reg[NSQ-1].nt * {1'b0, sq2_reg[NSQ-1].root};
            m_tir_reg <= sq2_carry_reg[NSQ-1].tir;
        end
    end

    // sum and difference
    function automatic fdr_pkg::lane_t lane_init(logic [fdr_pkg::AMP_W-1:0] p,
                                                 logic [fdr_pkg::AMP_W-1:0] q);
        fdr_pkg::lane_t l;
        l.s   = fdr_pkg::SUM_W'(p) + fdr_pkg::SUM_W'(q);
        l.rem = (p > q) ? fdr_pkg::SUM_W'(p - q) : fdr_pkg::SUM_W'(q - p);
        l.quo = '0;
        l.one = (l.s == '0) || (l.rem >= l.s);
        return l;
    endfunction

    fdr_pkg::lane_t l1_reg, l2_reg;
    logic           s_tir_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l1_reg    <= lane_init(p1_reg, q1_reg);
            l2_reg    <= lane_init(p2_reg, q2_reg);
            s_tir_reg <= m_tir_reg;
        end
    end

    // ratio dividers
    fdr_pkg::lane_t rt1_reg [NRT];
    fdr_pkg::lane_t rt2_reg [NRT];
    logic [NRT-1:0] rt_tir_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            rt_tir_reg <= {rt_tir_reg[NRT-2:0], s_tir_reg};
    end

    for (genvar i = 0; i < NRT; i++)
    begin : g_rt
        fdr_pkg::lane_t ln1_in;
        fdr_pkg::lane_t ln2_in;

        if (i == 0)
        begin : g_first
            assign ln1_in = l1_reg;
            assign ln2_in = l2_reg;
        end
        else
        begin : g_next
            assign ln1_in = rt1_reg[i-1];
            assign ln2_in = rt2_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rt1_reg[i] <= fdr_pkg::lane_step(ln1_in);
                rt2_reg[i] <= fdr_pkg::lane_step(ln2_in);
            end
        end
    end

    // squares
    logic [NRT:0]              r1, r2;
    logic [2*NRT+1:0]          r1_sq, r2_sq;
    logic [fdr_pkg::RSQ_W-1:0] sq_a_reg, sq_b_reg;
    logic                      q_tir_reg;

    assign r1    = rt1_reg[NRT-1].one ? ((NRT + 1)'(1) << NRT) : {1'b0, rt1_reg[NRT-1].quo};
    assign r2    = rt2_reg[NRT-1].one ? ((NRT + 1)'(1) << NRT) : {1'b0, rt2_reg[NRT-1].quo};
    assign r1_sq = r1 * r1;
    assign r2_sq = r2 * r2;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_a_reg  <= r1_sq[fdr_pkg::RSQ_W-1:0];
            sq_b_reg  <= r2_sq[fdr_pkg::RSQ_W-1:0];
            q_tir_reg <= rt_tir_reg[NRT-1];
        end
    end

    // mean, clamp and response register
    logic [fdr_pkg::RSQ_W:0]    sq_sum;
    logic [fdr_pkg::REFL_W-1:0] refl;
    fdr_pkg::rsp_t              rsp_reg;

    assign sq_sum = {1'b0, sq_a_reg} + {1'b0, sq_b_reg};
    assign refl   = fdr_pkg::REFL_W'(sq_sum >> fdr_pkg::REFL_SHIFT);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (q_tir_reg)
                rsp_reg.reflectance <= fdr_pkg::REFL_ONE;
            else
                rsp_reg.reflectance <= (refl > fdr_pkg::REFL_ONE) ? fdr_pkg::REFL_ONE : refl;
            rsp_reg.total_reflection <= q_tir_reg;
        end
    end

    assign rsp = rsp_reg;

    a_tir_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.total_reflection |-> rsp.reflectance == fdr_pkg::REFL_ONE)
        else $error("total reflection without full reflectance");

    a_refl_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.reflectance <= fdr_pkg::REFL_ONE)
        else $error("reflectance above one");

    a_entry: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> valid_reg[0])
        else $error("accepted request not in pipe");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipe moved while stalled");

    a_sin_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NSQ] |-> sq1_reg[NSQ-1].root <= fdr_pkg::ROOT_W'(fdr_pkg::COS_ONE))
        else $error("incident sine above one");

endmodule
